@@ sv/crt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_pkg: shared constants and types for the current ramp tracker
// Widths of the rate split (quotient and remainder by the control frequency).
// ----------------------------------------------------------------------------
package crt_pkg;

	localparam int CONTROL_FREQ = 20000;

	localparam int CUR_W   = 16;
	localparam int RATE_W  = 22;
	localparam int RATE_MAX = (1 << RATE_W) - 1;
	localparam int RATE_RESET = 4000;

	// rate = q * CONTROL_FREQ + r
	localparam int QW = $clog2(RATE_MAX / CONTROL_FREQ + 1);
	localparam int RW = (CONTROL_FREQ > 1) ? $clog2(CONTROL_FREQ) : 1;
	localparam int REM_W = RW + 1;
	localparam int SUM_W = RW + 2;
	localparam int DIV_W = RATE_W + QW;
	localparam int NW = ((CUR_W > QW + 2) ? CUR_W : QW + 2) + 1;

	// reciprocal of the control frequency, exact over the full rate range
	localparam int     RECIP_SH = RATE_W + RW;
	localparam int     RECIP_W  = RATE_W + 1;
	localparam int     PROD_W   = RATE_W + RECIP_W;
	localparam longint RECIP    = ((longint'(1) << RECIP_SH) + longint'(CONTROL_FREQ) - 1)
			/ longint'(CONTROL_FREQ);

	localparam logic [0:0] REG_UP_RATE   = 1'b0;
	localparam logic [0:0] REG_DOWN_RATE = 1'b1;

	localparam logic FUNC_TRACK  = 1'b0;
	localparam logic FUNC_PRESET = 1'b1;

	typedef struct packed {
		logic [QW-1:0] q;
		logic [RW-1:0] r;
	} split_t;

	// quotient by reciprocal multiply, remainder by one multiply-subtract
	function automatic split_t rate_split(input logic [RATE_W-1:0] rate);
		logic [PROD_W-1:0] prod;
		logic [DIV_W-1:0]  rem;
		split_t            res;
		prod  = PROD_W'(rate) * PROD_W'(RECIP);
		res.q = prod[RECIP_SH +: QW];
		rem   = DIV_W'(rate) - DIV_W'(res.q) * DIV_W'(CONTROL_FREQ);
		res.r = rem[RW-1:0];
		return res;
	endfunction

	localparam split_t RESET_SPLIT = rate_split(RATE_W'(RATE_RESET));

endpackage
`default_nettype wire

@@ sv/crt_rate_split.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_rate_split: rate register held as quotient and remainder
// Splits a written rate by the control frequency so the tick path needs no divider.
// ----------------------------------------------------------------------------
module crt_rate_split (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [crt_pkg::RATE_W-1:0] wdata,
	output crt_pkg::split_t                 split
);

	crt_pkg::split_t split_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= crt_pkg::RESET_SPLIT;
		end else if (wr_en) begin
			split_q <= crt_pkg::rate_split(wdata);
		end
	end

	assign split = split_q;

endmodule
`default_nettype wire

@@ sv/current_ramp_tracker_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// current_ramp_tracker_core: slew-rate limited current tracker
// Input word: func and current_value on in_valid/in_ready. func 0 steps the
// tracked current one control tick toward current_value; func 1 presets it.
// Output word: tracked_current on out_valid/out_ready, one per input word.
// Pipeline: input register, then update logic into output register.
// Throughput: one word per cycle while the output is not stalled; the tracked
// state updates from the pre-split rate registers; no word waits on an earlier one.
// A stalled receiver holds the output register; the input register fills
// and in_ready drops until the output word is taken.
// Config: cfg_wr_en writes cfg_wdata to up_rate (index 0) or down_rate
// (index 1) at once; write only while no word is in flight.
// Reset: tracked current and remainder clear, both rates return to 4000.
// ----------------------------------------------------------------------------
module current_ramp_tracker_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       func,
	input  wire logic signed [15:0]         current_value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [15:0]              tracked_current,
	input  wire logic                       cfg_wr_en,
	input  wire logic [0:0]                 cfg_addr,
	input  wire logic [crt_pkg::RATE_W-1:0] cfg_wdata
);

	localparam logic signed [crt_pkg::SUM_W-1:0] FREQ_S = crt_pkg::SUM_W'(crt_pkg::CONTROL_FREQ);

	crt_pkg::split_t up_split;
	crt_pkg::split_t dn_split;

	crt_rate_split u_up (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en && cfg_addr == crt_pkg::REG_UP_RATE),
		.wdata  (cfg_wdata),
		.split  (up_split)
	);

	crt_rate_split u_down (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en && cfg_addr == crt_pkg::REG_DOWN_RATE),
		.wdata  (cfg_wdata),
		.split  (dn_split)
	);

	logic                                v_s1;
	logic                                func_s1;
	logic signed [15:0]                  val_s1;
	logic                                adv;

	logic signed [15:0]                  cur_q;
	logic signed [crt_pkg::REM_W-1:0]    rem_q;
	logic                                out_valid_q;
	logic signed [15:0]                  tracked_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			val_s1  <= current_value;
		end
	end

	// tick update
	logic                                dir_up;
	logic                                use_up;
	logic [crt_pkg::QW-1:0]              sel_q;
	logic [crt_pkg::RW-1:0]              sel_r;
	logic signed [crt_pkg::REM_W-1:0]    rem_dir;
	logic signed [crt_pkg::SUM_W-1:0]    s;
	logic signed [crt_pkg::SUM_W-1:0]    rm;
	logic [crt_pkg::QW:0]                qm;
	logic signed [crt_pkg::QW+1:0]       step;
	logic signed [crt_pkg::NW-1:0]       n;
	logic signed [crt_pkg::NW-1:0]       tgt;
	logic                                clamp;
	logic signed [15:0]                  cur_nx;
	logic signed [crt_pkg::REM_W-1:0]    rem_nx;

	always_comb begin
		dir_up  = val_s1 > cur_q;
		use_up  = dir_up ? !cur_q[15] : (cur_q[15] || cur_q == '0);
		sel_q   = use_up ? up_split.q : dn_split.q;
		sel_r   = use_up ? up_split.r : dn_split.r;
		rem_dir = dir_up ? rem_q : -rem_q;
		s = $signed({2'b00, sel_r}) + $signed({rem_dir[crt_pkg::REM_W-1], rem_dir});

		priority if (s >= FREQ_S) begin
			qm = {1'b0, sel_q} + 1'b1;
			rm = s - FREQ_S;
		end else if (!s[crt_pkg::SUM_W-1]) begin
			qm = {1'b0, sel_q};
			rm = s;
		end else if (sel_q == '0) begin
			qm = '0;
			rm = s;
		end else begin
			qm = {1'b0, sel_q} - 1'b1;
			rm = s + FREQ_S;
		end

		step  = dir_up ? $signed({1'b0, qm}) : -$signed({1'b0, qm});
		n     = crt_pkg::NW'(cur_q) + crt_pkg::NW'(step);
		tgt   = use_up ? crt_pkg::NW'(val_s1) : '0;
		clamp = dir_up ? (n >= tgt) : (n <= tgt);

		if (func_s1 == crt_pkg::FUNC_PRESET) begin
			cur_nx = val_s1;
			rem_nx = '0;
		end else if (val_s1 == cur_q) begin
			cur_nx = cur_q;
			rem_nx = rem_q;
		end else if (clamp) begin
			cur_nx = tgt[15:0];
			rem_nx = '0;
		end else begin
			cur_nx = n[15:0];
			rem_nx = dir_up ? rm[crt_pkg::REM_W-1:0] : -rm[crt_pkg::REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
			if (v_s1) begin
				cur_q <= cur_nx;
				rem_q <= rem_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			tracked_q <= cur_nx;
		end
	end

	assign out_valid       = out_valid_q;
	assign tracked_current = tracked_q;

	// remainder stays strictly inside one control period
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		($signed({rem_q[crt_pkg::REM_W-1], rem_q}) < FREQ_S) &&
		($signed({rem_q[crt_pkg::REM_W-1], rem_q}) > -FREQ_S))
		else $error("remainder out of range");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> tracked_q == cur_q)
		else $error("output word differs from tracked state");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> out_valid_q)
		else $error("word lost between stages");

	a_preset: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv && func_s1 == crt_pkg::FUNC_PRESET) |=>
		(rem_q == '0 && cur_q == $past(val_s1)))
		else $error("preset not applied");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: current ramp tracker core
// Sends goal and preset words through the tracker and checks every tracked
// current against a scripted value or an independent slew-limited ramp model.
// The rate registers are changed between phases. A scripted part runs first,
// then random goal runs; both handshakes idle at random but in the last phase.
// ----------------------------------------------------------------------------
module testbench;

	localparam longint FREQ = longint'(crt_pkg::CONTROL_FREQ);
	localparam logic [crt_pkg::RATE_W-1:0] RMAX = crt_pkg::RATE_W'(crt_pkg::RATE_MAX);
	localparam logic [crt_pkg::RATE_W-1:0] RRST = crt_pkg::RATE_W'(crt_pkg::RATE_RESET);
	localparam logic signed [15:0] CUR_MIN = 16'sh8000;
	localparam logic signed [15:0] CUR_MAX = 16'sh7FFF;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 95;

	typedef struct packed {
		logic [crt_pkg::RATE_W-1:0] up;
		logic [crt_pkg::RATE_W-1:0] down;
		logic                       fn;
		logic signed [15:0]         value;
		logic                       known;
		logic signed [15:0]         want;
	} script_row_t;

	localparam int SCRIPT_LEN = 25;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{RRST, RRST, crt_pkg::FUNC_TRACK, 16'sd0, 1'b1, 16'sd0},
		'{RRST, RRST, crt_pkg::FUNC_PRESET, CUR_MAX, 1'b1, CUR_MAX},
		'{RRST, RRST, crt_pkg::FUNC_TRACK, CUR_MAX, 1'b1, CUR_MAX},
		'{RRST, RRST, crt_pkg::FUNC_TRACK, CUR_MIN, 1'b0, 16'sd0},
		'{RRST, RRST, crt_pkg::FUNC_PRESET, CUR_MIN, 1'b1, CUR_MIN},
		'{RRST, RRST, crt_pkg::FUNC_TRACK, CUR_MAX, 1'b0, 16'sd0},
		'{RRST, RRST, crt_pkg::FUNC_PRESET, 16'sd0, 1'b1, 16'sd0},
		'{RRST, RRST, crt_pkg::FUNC_TRACK, 16'sd3, 1'b0, 16'sd0},
		'{RRST, RRST, crt_pkg::FUNC_TRACK, -16'sd3, 1'b0, 16'sd0},
		'{RMAX, RMAX, crt_pkg::FUNC_PRESET, 16'sd100, 1'b1, 16'sd100},
		'{RMAX, RMAX, crt_pkg::FUNC_TRACK, CUR_MIN, 1'b1, 16'sd0},
		'{RMAX, RMAX, crt_pkg::FUNC_TRACK, CUR_MIN, 1'b0, 16'sd0},
		'{RMAX, RMAX, crt_pkg::FUNC_TRACK, -16'sd300, 1'b0, 16'sd0},
		'{RMAX, RMAX, crt_pkg::FUNC_TRACK, CUR_MAX, 1'b0, 16'sd0},
		'{RMAX, RMAX, crt_pkg::FUNC_PRESET, CUR_MAX, 1'b1, CUR_MAX},
		'{RMAX, RMAX, crt_pkg::FUNC_TRACK, CUR_MIN, 1'b0, 16'sd0},
		'{RMAX, RMAX, crt_pkg::FUNC_PRESET, CUR_MIN, 1'b1, CUR_MIN},
		'{RMAX, RMAX, crt_pkg::FUNC_TRACK, CUR_MIN, 1'b1, CUR_MIN},
		'{22'd0, 22'd0, crt_pkg::FUNC_PRESET, 16'sd50, 1'b1, 16'sd50},
		'{22'd0, 22'd0, crt_pkg::FUNC_TRACK, 16'sd1000, 1'b1, 16'sd50},
		'{22'd0, 22'd0, crt_pkg::FUNC_TRACK, -16'sd1000, 1'b1, 16'sd50},
		'{22'd19999, 22'd1, crt_pkg::FUNC_PRESET, 16'sd0, 1'b1, 16'sd0},
		'{22'd19999, 22'd1, crt_pkg::FUNC_TRACK, 16'sd10, 1'b1, 16'sd0},
		'{22'd19999, 22'd1, crt_pkg::FUNC_TRACK, 16'sd10, 1'b0, 16'sd0},
		'{22'd19999, 22'd1, crt_pkg::FUNC_TRACK, -16'sd10, 1'b0, 16'sd0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic                       func;
	logic signed [15:0]         current_value;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [15:0]         tracked_current;
	logic                       cfg_wr_en;
	logic [0:0]                 cfg_addr;
	logic [crt_pkg::RATE_W-1:0] cfg_wdata;

	logic [crt_pkg::RATE_W-1:0] rate_up;
	logic [crt_pkg::RATE_W-1:0] rate_down;
	longint                     model_cur;
	longint                     model_frac;
	logic signed [15:0]         tracked_due [$];
	int                         failures = 0;
	int                         gap_pct;
	bit                         calm;

	current_ramp_tracker_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.current_value   (current_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tracked_current (tracked_current),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata)
	);

	always #10 clk = ~clk;

	// add a signed rate to the fraction, return the stepped current
	function automatic longint ramp(input longint rate);
		longint acc;
		acc = model_frac + rate;
		model_frac = acc % FREQ;
		return model_cur + acc / FREQ;
	endfunction

	function automatic logic signed [15:0] next_tracked(input logic fn,
			input logic signed [15:0] value);
		longint goal;
		longint nxt;
		goal = longint'(value);
		if (fn == crt_pkg::FUNC_PRESET) begin
			model_cur = goal;
			model_frac = 0;
		end else if (goal > model_cur) begin
			if (model_cur >= 0) begin
				nxt = ramp(longint'(rate_up));
				if (nxt >= goal) begin
					nxt = goal;
					model_frac = 0;
				end
			end else begin
				nxt = ramp(longint'(rate_down));
				if (nxt >= 0) begin
					nxt = 0;
					model_frac = 0;
				end
			end
			model_cur = nxt;
		end else if (goal < model_cur) begin
			if (model_cur <= 0) begin
				nxt = ramp(-longint'(rate_up));
				if (nxt <= goal) begin
					nxt = goal;
					model_frac = 0;
				end
			end else begin
				nxt = ramp(-longint'(rate_down));
				if (nxt <= 0) begin
					nxt = 0;
					model_frac = 0;
				end
			end
			model_cur = nxt;
		end
		return 16'(model_cur);
	endfunction

	function automatic logic [crt_pkg::RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 3))
			0: return crt_pkg::RATE_W'($urandom_range(0, 40000));
			1: return crt_pkg::RATE_W'($urandom_range(0, crt_pkg::RATE_MAX));
			2: return RMAX - crt_pkg::RATE_W'($urandom_range(0, 1000));
			default: return crt_pkg::RATE_W'(crt_pkg::CONTROL_FREQ
					* int'($urandom_range(1, 200)) + int'($urandom_range(0, 2)) - 1);
		endcase
	endfunction

	task automatic push_word(input logic fn, input logic signed [15:0] value,
			input logic known, input logic signed [15:0] want);
		logic signed [15:0] due;
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		current_value <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		due = next_tracked(fn, value);
		tracked_due.push_back(known ? want : due);
	endtask

	// hold off until every word is back and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (tracked_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_rates(input logic [crt_pkg::RATE_W-1:0] up,
			input logic [crt_pkg::RATE_W-1:0] down);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_addr <= crt_pkg::REG_UP_RATE;
		cfg_wdata <= up;
		@(posedge clk);
		cfg_addr <= crt_pkg::REG_DOWN_RATE;
		cfg_wdata <= down;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rate_up = up;
		rate_down = down;
	endtask

	initial begin
		script_row_t                row;
		int                         run_left;
		int                         span;
		longint                     near;
		logic signed [15:0]         goal;
		logic                       fn;
		logic [crt_pkg::RATE_W-1:0] up;
		logic [crt_pkg::RATE_W-1:0] down;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = crt_pkg::FUNC_TRACK;
		current_value = '0;
		cfg_wr_en = 1'b0;
		cfg_addr = crt_pkg::REG_UP_RATE;
		cfg_wdata = '0;
		rate_up = RRST;
		rate_down = RRST;
		model_cur = 0;
		model_frac = 0;
		gap_pct = 20;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			row = SCRIPT[i];
			if (row.up != rate_up || row.down != rate_down)
				set_rates(row.up, row.down);
			push_word(row.fn, row.value, row.known, row.want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					up = RMAX;
					down = RMAX;
				end
				1: begin
					up = 22'd1;
					down = 22'd1;
				end
				2: begin
					up = '0;
					down = pick_rate();
				end
				3: begin
					up = pick_rate();
					down = '0;
				end
				default: begin
					up = pick_rate();
					down = pick_rate();
				end
			endcase
			set_rates(up, down);
			if (p == PHASES - 1) begin
				calm = 1'b1;
				gap_pct = 0;
			end else begin
				gap_pct = $urandom_range(0, 3) * 10;
			end
			span = (int'(rate_up) > int'(rate_down) ? int'(rate_up) : int'(rate_down))
					/ crt_pkg::CONTROL_FREQ * 8 + 4;
			run_left = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 4 && k == PHASE_ITEMS / 2)
					settle();
				if (run_left == 0) begin
					fn = crt_pkg::FUNC_TRACK;
					run_left = 1;
					case ($urandom_range(0, 9))
						0: begin
							fn = crt_pkg::FUNC_PRESET;
							goal = 16'($urandom);
						end
						1: begin
							fn = crt_pkg::FUNC_PRESET;
							goal = 16'(int'($urandom_range(0, 2 * span)) - span);
						end
						2: goal = 16'(model_cur);
						3: begin
							goal = 16'($urandom);
							run_left = $urandom_range(1, 30);
						end
						4: begin
							case ($urandom_range(0, 2))
								0: goal = 16'sd0;
								1: goal = CUR_MIN;
								default: goal = CUR_MAX;
							endcase
							run_left = $urandom_range(1, 30);
						end
						default: begin
							near = model_cur + longint'($urandom_range(0, 2 * span)) - span;
							if (near > 32767)
								near = 32767;
							if (near < -32768)
								near = -32768;
							goal = 16'(near);
							run_left = $urandom_range(1, 40);
						end
					endcase
				end
				run_left--;
				push_word(fn, goal, 1'b0, '0);
			end
		end

		settle();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (tracked_due.size() == 0) begin
				$display("%0t: unexpected word, tracked_current %0d", $time, tracked_current);
				failures++;
			end else begin
				want = tracked_due.pop_front();
				if (tracked_current !== want) begin
					$display("%0t: tracked_current expected %0d, got %0d",
							$time, want, tracked_current);
					failures++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
sv/crt_pkg.sv
sv/crt_rate_split.sv
sv/current_ramp_tracker_core.sv
tb/testbench.sv
